// ===== sv/cvr_pkg.sv =====
package cvr_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic               append;
        logic               remove;
        logic [VALUE_W-1:0] key;
    } cell_ctrl_t;

endpackage

// ===== sv/circular_value_ring_with_removal.sv =====
// channel | handshake          | payload
// input   | in_valid, in_stall | opcode, value
// output  | out_valid, out_stall | current_value, has_current, entry_count, status
//
// one word per cycle: each accepted word is resolved in its cycle by the row of
// cells (parallel compare, first-match chain, shift) and its result is registered.
// result appears the cycle after acceptance.
// reset empties the ring and clears the output valid; entry contents are not cleared.
// input stalls while a result is held and the output is stalled.
module circular_value_ring_with_removal #(
    parameter int DEPTH = cvr_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cvr_pkg::OP_W-1:0]       opcode,
    input  logic signed [cvr_pkg::VALUE_W-1:0] value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [cvr_pkg::VALUE_W-1:0] current_value,
    output logic                           has_current,
    output logic [cvr_pkg::COUNT_W-1:0]    entry_count,
    output logic [cvr_pkg::STATUS_W-1:0]   status
);
    import cvr_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             out_valid_reg, out_valid_next;

    logic signed [VALUE_W-1:0] current_value_reg;
    logic                      has_current_reg;
    logic [COUNT_W-1:0]        entry_count_reg;
    logic [STATUS_W-1:0]       status_reg, status_next;

    logic                            go;
    logic                            full;
    logic                            add_ok;
    logic                            rem;
    logic                            any_hit;
    logic                            before_cur;
    logic                            removed_cur;
    logic                            removed_tail;
    logic [IDX_W-1:0]                tail_idx;
    logic [CNT_W-1:0]                cur_inc;
    cell_ctrl_t                      ctrl;
    logic [DEPTH:0]                  seen_chain;
    logic [DEPTH-1:0]                first_vec;
    logic [DEPTH-1:0]                live_vec;
    logic [DEPTH-1:0]                wr_vec;
    logic [DEPTH-1:0][VALUE_W-1:0]   value_vec;
    logic [DEPTH-1:0][VALUE_W-1:0]   next_vec;

    assign in_stall = out_valid_reg && out_stall;
    assign go       = in_valid && !in_stall;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign add_ok  = go && (opcode == OP_APPEND) && !full;
    assign rem     = go && (opcode == OP_REMOVE);
    assign any_hit = seen_chain[DEPTH];

    assign ctrl.append = add_ok;
    assign ctrl.remove = rem;
    assign ctrl.key    = value;

    assign seen_chain[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [VALUE_W-1:0] right_value;

            assign live_vec[i] = (CNT_W'(i) < count_reg);
            assign wr_vec[i]   = (CNT_W'(i) == count_reg);

            if (i == DEPTH - 1)
            begin : g_last
                assign right_value = value_vec[i];
            end
            else
            begin : g_mid
                assign right_value = value_vec[i + 1];
            end

            cvr_cell u_cell (
                .clk          (clk),
                .ctrl         (ctrl),
                .live         (live_vec[i]),
                .wr_sel       (wr_vec[i]),
                .seen_in      (seen_chain[i]),
                .right_value  (right_value),
                .seen_out     (seen_chain[i + 1]),
                .first        (first_vec[i]),
                .stored_value (value_vec[i]),
                .stored_next  (next_vec[i])
            );
        end
    endgenerate

    assign tail_idx     = IDX_W'(count_reg - CNT_W'(1));
    assign before_cur   = seen_chain[cur_reg];
    assign removed_cur  = first_vec[cur_reg];
    assign removed_tail = first_vec[tail_idx];
    assign cur_inc      = CNT_W'(cur_reg) + CNT_W'(1);

    always_comb
    begin
        count_next  = count_reg;
        cur_next    = cur_reg;
        status_next = ST_DONE;
        if (go)
        begin
            case (opcode)
                OP_APPEND:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    if (!any_hit)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        if (before_cur)
                        begin
                            cur_next = cur_reg - IDX_W'(1);
                        end
                        else if (removed_cur && removed_tail)
                        begin
                            cur_next = '0;
                        end
                        if (count_reg == CNT_W'(1))
                        begin
                            cur_next = '0;
                        end
                    end
                end
                OP_ADVANCE:
                begin
                    if (count_reg != '0)
                    begin
                        if (cur_inc >= count_reg)
                        begin
                            cur_next = '0;
                        end
                        else
                        begin
                            cur_next = IDX_W'(cur_inc);
                        end
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            if (count_next != '0)
            begin
                current_value_reg <= next_vec[cur_next];
                has_current_reg   <= 1'b1;
            end
            else
            begin
                current_value_reg <= -VALUE_W'(1);
                has_current_reg   <= 1'b0;
            end
            entry_count_reg <= COUNT_W'(count_next);
            status_reg      <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign current_value = current_value_reg;
    assign has_current   = has_current_reg;
    assign entry_count   = entry_count_reg;
    assign status        = status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("ring count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CNT_W'(cur_reg) < count_reg))
        else $error("current slot outside held entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (cur_reg == '0))
        else $error("current slot not zero on empty ring");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_vec))
        else $error("more than one first match");

    assert property (@(posedge clk) disable iff (!rst_n)
        go |=> out_valid_reg)
        else $error("accepted word produced no result");

endmodule

// ===== sv/cvr_cell.sv =====
module cvr_cell (
    input  logic                        clk,
    input  cvr_pkg::cell_ctrl_t         ctrl,
    input  logic                        live,
    input  logic                        wr_sel,
    input  logic                        seen_in,
    input  logic [cvr_pkg::VALUE_W-1:0] right_value,
    output logic                        seen_out,
    output logic                        first,
    output logic [cvr_pkg::VALUE_W-1:0] stored_value,
    output logic [cvr_pkg::VALUE_W-1:0] stored_next
);
    import cvr_pkg::*;

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               match;

    assign match    = live && (value_reg == ctrl.key);
    assign seen_out = seen_in || match;
    assign first    = match && !seen_in;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.append && wr_sel)
        begin
            value_next = ctrl.key;
        end
        else if (ctrl.remove && seen_out)
        begin
            // close the gap left by the removed entry
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign stored_value = value_reg;
    assign stored_next  = value_next;

endmodule
